// File: design/spi_led_command_parser_defines.svh
// ---------------------------------------------------------------------------
// spi_led_command_parser_defines.svh
// Assertion macros used by the parser's port-level checker.
// ---------------------------------------------------------------------------
`ifndef SPI_LED_COMMAND_PARSER_DEFINES_SVH
`define SPI_LED_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc check failed");

// next-cycle implication, sampled on clk, off during reset
`define SLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc check failed");

`endif

// File: design/slc_pkg.sv
// ---------------------------------------------------------------------------
// slc_pkg
// Types, codes and constants of the SPI LED command parser.
// ---------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned MATRIX_DEPTH  = 1024;
  localparam int unsigned MATRIX_ADDR_W = 10;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned COL_W         = 17;

  localparam logic [7:0] DELAY_RESET = 8'd30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_FINISH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_FINISH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX    = 3'd5;

  // message ids
  localparam logic [7:0] MSG_START     = 8'd0;
  localparam logic [7:0] MSG_STOP      = 8'd1;
  localparam logic [7:0] MSG_HANDSHAKE = 8'd2;
  localparam logic [7:0] MSG_MATRIX    = 8'd3;
  localparam logic [7:0] MSG_DELAY     = 8'd4;
  localparam logic [7:0] MSG_BRIGHT    = 8'd5;
  localparam logic [7:0] MSG_RELAY     = 8'd6;

  // reply status
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_FINISH    = 2'd1;
  localparam logic [1:0] ST_BAD_ID       = 2'd2;
  localparam logic [1:0] ST_BRIGHT_RANGE = 2'd3;

  // display commands
  localparam logic [1:0] DISP_NONE  = 2'd0;
  localparam logic [1:0] DISP_START = 2'd1;
  localparam logic [1:0] DISP_STOP  = 2'd2;

  // reply byte positions
  localparam logic [1:0] RPOS_STATUS = 2'd1;
  localparam logic [1:0] RPOS_FINISH = 2'd2;

  typedef struct packed {
    logic [7:0] slave_start;
    logic [7:0] slave_finish;
    logic [7:0] master_start;
    logic [7:0] master_finish;
    logic [7:0] bright_min;
    logic [7:0] bright_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    slave_start:   8'd0,
    slave_finish:  8'd255,
    master_start:  8'd0,
    master_finish: 8'd255,
    bright_min:    8'd0,
    bright_max:    8'd15
  };

  typedef struct packed {
    logic [7:0]               tx_byte;
    logic                     matrix_we;
    logic [MATRIX_ADDR_W-1:0] matrix_addr;
    logic [7:0]               matrix_data;
    logic                     matrix_busy;
    logic [15:0]              matrix_length;
    logic [1:0]               display_cmd;
    logic                     brightness_we;
    logic [7:0]               brightness_value;
    logic                     relay_we;
    logic                     relay_on;
    logic [7:0]               scroll_delay;
  } res_t;

endpackage

// File: design/slc_cfg_regs.sv
// ---------------------------------------------------------------------------
// slc_cfg_regs
// Configuration register file; unlisted indexes are ignored.
// ---------------------------------------------------------------------------
module slc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [7:0]                     wr_data,
  output slc_pkg::cfg_t                  cfg
);
  import slc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SLAVE_START:   cfg_nxt.slave_start   = wr_data;
        REG_SLAVE_FINISH:  cfg_nxt.slave_finish  = wr_data;
        REG_MASTER_START:  cfg_nxt.master_start  = wr_data;
        REG_MASTER_FINISH: cfg_nxt.master_finish = wr_data;
        REG_BRIGHT_MIN:    cfg_nxt.bright_min    = wr_data;
        REG_BRIGHT_MAX:    cfg_nxt.bright_max    = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/slc_core.sv
// ---------------------------------------------------------------------------
// slc_core
// Message framing state and the per-byte decision logic.
// ---------------------------------------------------------------------------
module slc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    rx_byte,
  input  slc_pkg::cfg_t cfg,
  output slc_pkg::res_t res
);
  import slc_pkg::*;

  logic             sending_r, sending_nxt;
  logic [2:0]       bcnt_r, bcnt_nxt;
  logic [7:0]       msg_id_r, msg_id_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             active_r, active_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [1:0]       rpos_r, rpos_nxt;
  logic [7:0]       delay_r, delay_nxt;

  logic       rep_go;
  logic [1:0] rep_st;
  logic [1:0] fin_st;
  logic [1:0] rpos_inc;

  always_comb begin
    sending_nxt = sending_r;
    bcnt_nxt    = bcnt_r;
    msg_id_nxt  = msg_id_r;
    held_nxt    = held_r;
    len_nxt     = len_r;
    col_nxt     = col_r;
    active_nxt  = active_r;
    status_nxt  = status_r;
    rpos_nxt    = rpos_r;
    delay_nxt   = delay_r;
    res         = '0;
    rep_go      = 1'b0;
    rep_st      = ST_OK;
    fin_st      = (rx_byte == cfg.slave_finish) ? ST_OK : ST_NO_FINISH;
    rpos_inc    = rpos_r + 2'd1;

    if (sending_r) begin
      rpos_nxt = rpos_inc;
      if (rpos_inc == RPOS_STATUS) begin
        res.tx_byte = {6'd0, status_r};
      end else if (rpos_inc == RPOS_FINISH) begin
        res.tx_byte = cfg.master_finish;
      end else begin
        sending_nxt = 1'b0;
        rpos_nxt    = 2'd0;
        bcnt_nxt    = 3'd0;
      end
    end else if (bcnt_r == 3'd0) begin
      if (rx_byte == cfg.slave_start) bcnt_nxt = 3'd1;
    end else if (bcnt_r == 3'd1) begin
      msg_id_nxt = rx_byte;
      bcnt_nxt   = 3'd2;
    end else begin
      unique case (msg_id_r)
        MSG_START, MSG_STOP, MSG_HANDSHAKE: begin
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd2) begin
            if (msg_id_r == MSG_START) res.display_cmd = DISP_START;
            else if (msg_id_r == MSG_STOP) res.display_cmd = DISP_STOP;
            rep_go = 1'b1;
            rep_st = fin_st;
          end
        end
        MSG_MATRIX: begin
          active_nxt = 1'b1;
          if (bcnt_r == 3'd2) begin
            len_nxt  = {8'd0, rx_byte};
            bcnt_nxt = 3'd3;
          end else if (bcnt_r == 3'd3) begin
            // low + 255 * high
            len_nxt  = len_r + ({rx_byte, 8'd0} - {8'd0, rx_byte});
            bcnt_nxt = 3'd4;
          end else if (bcnt_r == 3'd4) begin
            col_nxt  = '0;
            bcnt_nxt = 3'd5;
          end else if (col_r < {1'b0, len_r}) begin
            if (col_r < COL_W'(MATRIX_DEPTH)) begin
              res.matrix_we   = 1'b1;
              res.matrix_addr = col_r[MATRIX_ADDR_W-1:0];
              res.matrix_data = rx_byte;
            end
            col_nxt = col_r + COL_W'(1);
          end else if (col_r == {1'b0, len_r}) begin
            col_nxt = col_r + COL_W'(1);
          end else begin
            active_nxt = 1'b0;
            rep_go     = 1'b1;
            rep_st     = fin_st;
          end
        end
        MSG_DELAY: begin
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd3) begin
            delay_nxt = rx_byte;
          end else if (bcnt_r != 3'd2) begin
            rep_go = 1'b1;
            rep_st = fin_st;
          end
        end
        MSG_BRIGHT: begin
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd2) begin
            held_nxt = rx_byte;
          end else if (held_r < cfg.bright_min || held_r > cfg.bright_max) begin
            rep_go = 1'b1;
            rep_st = ST_BRIGHT_RANGE;
          end else begin
            res.brightness_we    = 1'b1;
            res.brightness_value = held_r;
            rep_go = 1'b1;
            rep_st = fin_st;
          end
        end
        MSG_RELAY: begin
          bcnt_nxt = bcnt_r + 3'd1;
          if (bcnt_r == 3'd2) begin
            held_nxt = rx_byte;
          end else begin
            res.relay_we = 1'b1;
            res.relay_on = (held_r != 8'd0);
            rep_go = 1'b1;
            rep_st = fin_st;
          end
        end
        default: begin
          // unknown id: skip until the finish byte
          if (rx_byte == cfg.slave_finish) begin
            rep_go = 1'b1;
            rep_st = ST_BAD_ID;
          end
        end
      endcase
    end

    if (rep_go) begin
      sending_nxt = 1'b1;
      rpos_nxt    = 2'd0;
      status_nxt  = rep_st;
      res.tx_byte = cfg.master_start;
    end

    res.matrix_busy   = active_nxt;
    res.matrix_length = len_nxt;
    res.scroll_delay  = delay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      bcnt_r    <= 3'd0;
      len_r     <= 16'd0;
      col_r     <= '0;
      active_r  <= 1'b0;
      status_r  <= ST_OK;
      rpos_r    <= 2'd0;
      delay_r   <= DELAY_RESET;
    end else if (step_en) begin
      sending_r <= sending_nxt;
      bcnt_r    <= bcnt_nxt;
      len_r     <= len_nxt;
      col_r     <= col_nxt;
      active_r  <= active_nxt;
      status_r  <= status_nxt;
      rpos_r    <= rpos_nxt;
      delay_r   <= delay_nxt;
    end
  end

  // written before read, no reset
  always_ff @(posedge clk) begin
    if (step_en) begin
      msg_id_r <= msg_id_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

// File: design/spi_led_command_parser.sv
// ---------------------------------------------------------------------------
// spi_led_command_parser
// Takes one received SPI byte per request and returns the byte to shift out
// next together with matrix, display, brightness and relay strobes. A request
// is registered on entry, decided by the framing logic in one pass and held
// in the result register, so one byte is taken every clock cycle unless the
// result side stalls; the entry register only stalls when the result
// register is full and stalled. Configuration writes are always ready and
// take effect on the next cycle.
// ---------------------------------------------------------------------------
module spi_led_command_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_tx_byte,
  output logic                          out_matrix_we,
  output logic [9:0]                    out_matrix_addr,
  output logic [7:0]                    out_matrix_data,
  output logic                          out_matrix_busy,
  output logic [15:0]                   out_matrix_length,
  output logic [1:0]                    out_display_cmd,
  output logic                          out_brightness_we,
  output logic [7:0]                    out_brightness_value,
  output logic                          out_relay_we,
  output logic                          out_relay_on,
  output logic [7:0]                    out_scroll_delay,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import slc_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       res_r;
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_rx_r;
  logic       out_vld_r, out_vld_nxt;
  logic       advance;
  logic       in_take;

  assign cfg_ready = 1'b1;

  slc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  slc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_rx_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) in_vld_nxt = 1'b1;
    else if (advance) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (advance) out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_rx_r <= in_rx_byte;
    if (advance) res_r <= res;
  end

  assign out_valid            = out_vld_r;
  assign out_tx_byte          = res_r.tx_byte;
  assign out_matrix_we        = res_r.matrix_we;
  assign out_matrix_addr      = res_r.matrix_addr;
  assign out_matrix_data      = res_r.matrix_data;
  assign out_matrix_busy      = res_r.matrix_busy;
  assign out_matrix_length    = res_r.matrix_length;
  assign out_display_cmd      = res_r.display_cmd;
  assign out_brightness_we    = res_r.brightness_we;
  assign out_brightness_value = res_r.brightness_value;
  assign out_relay_we         = res_r.relay_we;
  assign out_relay_on         = res_r.relay_on;
  assign out_scroll_delay     = res_r.scroll_delay;

endmodule

// File: design/slc_checker.sv
// ---------------------------------------------------------------------------
// slc_checker
// Port-level checks on the SPI LED command parser results.
// ---------------------------------------------------------------------------
`include "spi_led_command_parser_defines.svh"

module slc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_tx_byte,
  input logic        out_matrix_we,
  input logic [9:0]  out_matrix_addr,
  input logic [7:0]  out_matrix_data,
  input logic        out_matrix_busy,
  input logic [1:0]  out_display_cmd,
  input logic        out_brightness_we,
  input logic        out_relay_we
);
  import slc_pkg::*;

  logic disp_any;
  assign disp_any = (out_display_cmd != DISP_NONE);

  // column writes only happen inside an upload
  `SLC_ASSERT_NOW(a_we_busy, out_valid && out_matrix_we, out_matrix_busy)
  // one strobe kind per result at most
  `SLC_ASSERT_NOW(a_one_strobe, out_valid,
    $countones({out_matrix_we, out_brightness_we, out_relay_we, disp_any}) <= 1)
  // idle write port carries zeros
  `SLC_ASSERT_NOW(a_idle_port, out_valid && !out_matrix_we,
    out_matrix_addr == 10'd0 && out_matrix_data == 8'd0)
  // stalled result holds
  `SLC_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(out_tx_byte) && $stable(out_display_cmd))

endmodule

bind spi_led_command_parser slc_checker u_slc_checker (.*);

// File: tb/slc_reply_checker.sv
// ----------------------------------------------------------------------------
// slc_reply_checker
// Watches the request, result and register channels of the SPI LED command
// parser. Every accepted request is run through a cycle-free model of the
// framing logic; the predicted reply is queued and compared field by field
// with the next result the block hands over.
// ----------------------------------------------------------------------------
module slc_reply_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_tx_byte,
  input  logic                          out_matrix_we,
  input  logic [9:0]                    out_matrix_addr,
  input  logic [7:0]                    out_matrix_data,
  input  logic                          out_matrix_busy,
  input  logic [15:0]                   out_matrix_length,
  input  logic [1:0]                    out_display_cmd,
  input  logic                          out_brightness_we,
  input  logic [7:0]                    out_brightness_value,
  input  logic                          out_relay_we,
  input  logic                          out_relay_on,
  input  logic [7:0]                    out_scroll_delay,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int unsigned                   mismatch_total,
  output int unsigned                   replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  cfg_t             regs;
  logic             replying;
  logic [2:0]       byte_count;
  logic [7:0]       msg_id;
  logic [7:0]       held_arg;
  logic [15:0]      upload_len;
  logic [COL_W-1:0] col_idx;
  logic             uploading;
  logic [1:0]       status;
  logic [1:0]       reply_pos;
  logic [7:0]       delay;

  res_t replies_due[$];
  int unsigned errors = 0;

  assign mismatch_total = errors;

  function automatic logic [1:0] close_status(input logic [7:0] rx);
    return (rx == regs.slave_finish) ? ST_OK : ST_NO_FINISH;
  endfunction

  // starts the three-byte reply and gives its first byte
  function automatic logic [7:0] open_reply(input logic [1:0] st);
    replying  = 1'b1;
    reply_pos = 2'd0;
    status    = st;
    return regs.master_start;
  endfunction

  function automatic res_t advance_parser(input logic [7:0] rx);
    res_t       r;
    logic [2:0] c;
    r = '0;
    c = byte_count;
    if (replying) begin
      reply_pos = reply_pos + 2'd1;
      if (reply_pos == RPOS_STATUS) begin
        r.tx_byte = {6'd0, status};
      end else if (reply_pos == RPOS_FINISH) begin
        r.tx_byte = regs.master_finish;
      end else begin
        replying   = 1'b0;
        reply_pos  = 2'd0;
        byte_count = 3'd0;
      end
    end else if (c == 3'd0) begin
      if (rx == regs.slave_start) byte_count = 3'd1;
    end else if (c == 3'd1) begin
      msg_id     = rx;
      byte_count = 3'd2;
    end else begin
      case (msg_id)
        MSG_START, MSG_STOP, MSG_HANDSHAKE: begin
          byte_count = c + 3'd1;
          if (c == 3'd2) begin
            if (msg_id == MSG_START) r.display_cmd = DISP_START;
            else if (msg_id == MSG_STOP) r.display_cmd = DISP_STOP;
            r.tx_byte = open_reply(close_status(rx));
          end
        end
        MSG_MATRIX: begin
          uploading = 1'b1;
          if (c == 3'd2) begin
            upload_len = {8'd0, rx};
            byte_count = 3'd3;
          end else if (c == 3'd3) begin
            upload_len = upload_len + 16'd255 * {8'd0, rx};
            byte_count = 3'd4;
          end else if (c == 3'd4) begin
            col_idx    = '0;
            byte_count = 3'd5;
          end else if (col_idx < {1'b0, upload_len}) begin
            if (col_idx < MATRIX_DEPTH) begin
              r.matrix_we   = 1'b1;
              r.matrix_addr = col_idx[MATRIX_ADDR_W-1:0];
              r.matrix_data = rx;
            end
            col_idx = col_idx + 1'b1;
          end else if (col_idx == {1'b0, upload_len}) begin
            col_idx = col_idx + 1'b1;
          end else begin
            uploading = 1'b0;
            r.tx_byte = open_reply(close_status(rx));
          end
        end
        MSG_DELAY: begin
          byte_count = c + 3'd1;
          if (c == 3'd3) delay = rx;
          else if (c != 3'd2) r.tx_byte = open_reply(close_status(rx));
        end
        MSG_BRIGHT: begin
          byte_count = c + 3'd1;
          if (c == 3'd2) begin
            held_arg = rx;
          end else if (held_arg < regs.bright_min || held_arg > regs.bright_max) begin
            r.tx_byte = open_reply(ST_BRIGHT_RANGE);
          end else begin
            r.brightness_we    = 1'b1;
            r.brightness_value = held_arg;
            r.tx_byte          = open_reply(close_status(rx));
          end
        end
        MSG_RELAY: begin
          byte_count = c + 3'd1;
          if (c == 3'd2) begin
            held_arg = rx;
          end else begin
            r.relay_we = 1'b1;
            r.relay_on = (held_arg != 8'd0);
            r.tx_byte  = open_reply(close_status(rx));
          end
        end
        default: begin
          if (rx == regs.slave_finish) r.tx_byte = open_reply(ST_BAD_ID);
        end
      endcase
    end
    r.matrix_busy   = uploading;
    r.matrix_length = upload_len;
    r.scroll_delay  = delay;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs       = CFG_RESET;
      replying   = 1'b0;
      byte_count = 3'd0;
      msg_id     = 8'd0;
      held_arg   = 8'd0;
      upload_len = 16'd0;
      col_idx    = '0;
      uploading  = 1'b0;
      status     = ST_OK;
      reply_pos  = 2'd0;
      delay      = DELAY_RESET;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLAVE_START:   regs.slave_start   = cfg_data;
          REG_SLAVE_FINISH:  regs.slave_finish  = cfg_data;
          REG_MASTER_START:  regs.master_start  = cfg_data;
          REG_MASTER_FINISH: regs.master_finish = cfg_data;
          REG_BRIGHT_MIN:    regs.bright_min    = cfg_data;
          REG_BRIGHT_MAX:    regs.bright_max    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) replies_due.push_back(advance_parser(in_rx_byte));
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t ns: result expected none, got tx_byte %0h", $time, out_tx_byte);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("matrix_we", want.matrix_we, out_matrix_we);
          check_field("matrix_addr", want.matrix_addr, out_matrix_addr);
          check_field("matrix_data", want.matrix_data, out_matrix_data);
          check_field("matrix_busy", want.matrix_busy, out_matrix_busy);
          check_field("matrix_length", want.matrix_length, out_matrix_length);
          check_field("display_cmd", want.display_cmd, out_display_cmd);
          check_field("brightness_we", want.brightness_we, out_brightness_we);
          check_field("brightness_value", want.brightness_value, out_brightness_value);
          check_field("relay_we", want.relay_we, out_relay_we);
          check_field("relay_on", want.relay_on, out_relay_on);
          check_field("scroll_delay", want.scroll_delay, out_scroll_delay);
        end
      end
    end
    replies_pending <= replies_due.size();
  end

endmodule

// File: tb/spi_led_command_parser_tb.sv
// ----------------------------------------------------------------------------
// spi_led_command_parser_tb
// Drives SPI byte requests into the command parser: a short directed run of
// message types and framing faults, then random messages, mostly well-formed,
// with some noise, wrong and cut-off frames under several register settings. Gaps on the
// request side and stalls on the result side are random. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module spi_led_command_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  typedef enum logic [1:0] {END_GOOD, END_WRONG, END_MISSING} frame_end_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_tx_byte;
  logic                 out_matrix_we;
  logic [9:0]           out_matrix_addr;
  logic [7:0]           out_matrix_data;
  logic                 out_matrix_busy;
  logic [15:0]          out_matrix_length;
  logic [1:0]           out_display_cmd;
  logic                 out_brightness_we;
  logic [7:0]           out_brightness_value;
  logic                 out_relay_we;
  logic                 out_relay_on;
  logic [7:0]           out_scroll_delay;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLAVE_START;
  logic [7:0]           cfg_data = 8'd0;
  int unsigned          mismatch_total;
  int unsigned          replies_pending;

  cfg_t        settings = CFG_RESET;
  logic [7:0]  frame[$];
  int unsigned framed_items = 0;
  int unsigned gap_mode = 0;
  int unsigned mode_left = 0;

  spi_led_command_parser i_dut (.*);

  slc_reply_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #15ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result-side back-pressure: free runs, choppy stretches and long holds
  initial begin
    int unsigned roll;
    int unsigned run;
    logic        level;
    forever begin
      roll = $urandom_range(0, 9);
      if (roll < 3) begin
        level = 1'b0;
        run   = $urandom_range(10, 60);
      end else if (roll < 9) begin
        level = 1'($urandom_range(0, 1));
        run   = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        run   = $urandom_range(10, 40);
      end
      out_stall <= level;
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (mode_left == 0) begin
      gap_mode  = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 80);
    end
    mode_left--;
    case (gap_mode)
      0: gap = 0;
      1: gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
      default: gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 4);
    endcase
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame();
    while (frame.size() != 0) send_byte(frame.pop_front());
  endtask

  task automatic queue_message(input logic [7:0] id, input logic [7:0] arg,
                               input logic [7:0] len_lo, input logic [7:0] len_hi,
                               input frame_end_t how);
    int unsigned first;
    int unsigned cols;
    logic [7:0]  fin;
    first = frame.size();
    fin   = settings.slave_finish;
    if (how == END_WRONG && id <= MSG_RELAY) fin = fin ^ 8'($urandom_range(1, 255));
    frame.push_back(settings.slave_start);
    frame.push_back(id);
    case (id)
      MSG_START, MSG_STOP, MSG_HANDSHAKE: ;
      MSG_MATRIX: begin
        frame.push_back(len_lo);
        frame.push_back(len_hi);
        frame.push_back(8'($urandom));
        cols = len_lo + 255 * len_hi;
        repeat (cols) frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
      end
      MSG_DELAY: begin
        frame.push_back(8'($urandom));
        frame.push_back(arg);
      end
      MSG_BRIGHT, MSG_RELAY: frame.push_back(arg);
      default: begin
        repeat (arg[1:0]) frame.push_back(settings.slave_finish ^ 8'($urandom_range(1, 255)));
      end
    endcase
    if (how != END_MISSING) frame.push_back(fin);
    framed_items += frame.size() - first;
    // the reply window swallows three requests
    if (how != END_MISSING) repeat (3) frame.push_back(8'($urandom));
  endtask

  task automatic random_message();
    logic [7:0]  id;
    logic [7:0]  arg;
    logic [7:0]  len_lo;
    logic [7:0]  len_hi;
    int unsigned roll;
    frame_end_t  how;
    id  = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(7, 255)) : 8'($urandom_range(0, 6));
    arg = 8'($urandom);
    if (id == MSG_BRIGHT && $urandom_range(0, 9) < 7) begin
      arg = 8'($urandom_range(settings.bright_min, settings.bright_max));
    end
    if (id == MSG_RELAY && $urandom_range(0, 3) == 0) arg = 8'd0;
    len_lo = 8'($urandom_range(0, 12));
    len_hi = 8'd0;
    if ($urandom_range(0, 49) == 0) begin
      len_lo = 8'($urandom);
      len_hi = 8'($urandom_range(0, 1));
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) how = END_GOOD;
    else if (roll < 94 || id == MSG_MATRIX) how = END_WRONG;
    else how = END_MISSING;
    queue_message(id, arg, len_lo, len_hi, how);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) frame.push_back(settings.slave_start ^ 8'($urandom_range(1, 255)));
    end
    send_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    cfg_t        s;
    int unsigned p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    frame.push_back(8'h5A);
    queue_message(MSG_START, 8'd0, 8'd0, 8'd0, END_GOOD);
    queue_message(MSG_STOP, 8'd0, 8'd0, 8'd0, END_WRONG);
    queue_message(MSG_MATRIX, 8'd0, 8'd1, 8'd0, END_GOOD);
    queue_message(MSG_BRIGHT, 8'd16, 8'd0, 8'd0, END_GOOD);
    queue_message(MSG_RELAY, 8'h80, 8'd0, 8'd0, END_GOOD);
    queue_message(MSG_DELAY, 8'hFF, 8'd0, 8'd0, END_GOOD);
    queue_message(8'hFF, 8'd1, 8'd0, 8'd0, END_GOOD);
    send_frame();

    for (p = 1; p <= 5; p++) begin
      drain();
      if (p == 1) begin
        s = '{slave_start: 8'hFF, slave_finish: 8'h00, master_start: 8'hFF,
              master_finish: 8'h00, bright_min: 8'h00, bright_max: 8'hFF};
      end else begin
        s.slave_start   = 8'($urandom);
        s.slave_finish  = 8'($urandom);
        s.master_start  = 8'($urandom);
        s.master_finish = 8'($urandom);
        s.bright_min    = 8'($urandom);
        s.bright_max    = 8'($urandom);
        if (p == 3) begin
          s.bright_min = 8'($urandom_range(128, 255));
          s.bright_max = 8'($urandom_range(0, 127));
        end
        if (p == 4) begin
          s.slave_finish = s.slave_start;
          s.bright_max   = s.bright_min;
        end
      end
      write_reg(REG_SLAVE_START, s.slave_start);
      write_reg(REG_SLAVE_FINISH, s.slave_finish);
      write_reg(REG_MASTER_START, s.master_start);
      write_reg(REG_MASTER_FINISH, s.master_finish);
      write_reg(REG_BRIGHT_MIN, s.bright_min);
      write_reg(REG_BRIGHT_MAX, s.bright_max);
      cfg_valid <= 1'b0;
      settings = s;
      if (p == 2) begin
        // runs past the end of the matrix store
        queue_message(MSG_MATRIX, 8'd0, 8'($urandom_range(5, 15)), 8'd4, END_GOOD);
        send_frame();
      end
      framed_items = 0;
      while (framed_items < 64) random_message();
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_total == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
